@@ rtl/free_block_stack_with_spill_core_defines.svh @@
// ----------------------------------------------------------------------------
// free_block_stack_with_spill_core_defines
// Assertion macros shared by the free block stack RTL.
// ----------------------------------------------------------------------------
`ifndef FREE_BLOCK_STACK_WITH_SPILL_CORE_DEFINES_SVH
`define FREE_BLOCK_STACK_WITH_SPILL_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define FBS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define FBS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/fbs_pkg.sv @@
// ----------------------------------------------------------------------------
// fbs_pkg
// Types, codes and widths shared by the free block stack modules.
// ----------------------------------------------------------------------------
package fbs_pkg;

  localparam int BLOCK_W   = 32;
  localparam int KIND_W    = 3;
  localparam int SLOT_W    = 6;
  localparam int REQ_W     = 2;
  localparam int ADDR_W    = 6;   // holds any stack index up to the largest depth
  localparam int DEPTH_DEF = 32;
  localparam int Q_DEPTH   = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_RECLAIM = 2'd1,
    REQ_REFILL  = 2'd2,
    REQ_WDONE   = 2'd3
  } req_t;

  typedef enum logic [KIND_W-1:0] {
    K_GRANT     = 3'd0,
    K_EMPTY     = 3'd1,
    K_READ      = 3'd2,
    K_SPILL     = 3'd3,
    K_WRITE     = 3'd4,
    K_RECLAIMED = 3'd5,
    K_IOERR     = 3'd6,
    K_BUSY      = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_REFILL = 2'd1,
    MODE_WRITE  = 2'd2
  } mode_t;

  // Work orders handed from the front to the back
  typedef enum logic [1:0] {
    OP_EMIT  = 2'd0,
    OP_PUSH  = 2'd1,
    OP_POP   = 2'd2,
    OP_SPILL = 2'd3
  } op_t;

  typedef struct packed {
    op_t                op;
    kind_t              kind;
    logic [ADDR_W-1:0]  addr;
    logic [BLOCK_W-1:0] data;
    logic               use_pend;  // take the block from the pending register
    logic               emit;      // push also produces a result
    logic               refill;    // pop empties the stack: follow with a read request
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE    = 3'd0,
    BK_EXEC    = 3'd1,
    BK_RDATA   = 3'd2,
    BK_READREQ = 3'd3,
    BK_SPILL   = 3'd4,
    BK_WRREQ   = 3'd5
  } bk_state_t;

endpackage

@@ rtl/fbs_if.sv @@
// ----------------------------------------------------------------------------
// fbs_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface fbs_in_if;
  logic                        valid;
  logic                        ready;
  logic [fbs_pkg::REQ_W-1:0]   req_type;
  logic [fbs_pkg::BLOCK_W-1:0] block_number;
  logic [fbs_pkg::BLOCK_W-1:0] refill_word;
  logic                        io_ok;

  modport source (output valid, req_type, block_number, refill_word, io_ok, input ready);
  modport sink   (input valid, req_type, block_number, refill_word, io_ok, output ready);
endinterface

interface fbs_out_if;
  logic                        valid;
  logic                        ready;
  logic [fbs_pkg::KIND_W-1:0]  result_kind;
  logic [fbs_pkg::BLOCK_W-1:0] result_block;
  logic [fbs_pkg::SLOT_W-1:0]  slot_index;
  logic                        last_result;

  modport source (output valid, result_kind, result_block, slot_index, last_result,
                  input ready);
  modport sink   (input valid, result_kind, result_block, slot_index, last_result,
                  output ready);
endinterface

@@ rtl/fbs_queue.sv @@
// ----------------------------------------------------------------------------
// fbs_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module fbs_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  fbs_pkg::cmd_t din,
  output logic          full,
  output logic          valid,
  input  logic          pop,
  output fbs_pkg::cmd_t dout
);
  import fbs_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  cmd_t             slot_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(Q_DEPTH));
  assign valid   = (cnt_r != '0);
  assign dout    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = CNT_W'(cnt_r + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = CNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the incoming command
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

endmodule

@@ rtl/fbs_front.sv @@
// ----------------------------------------------------------------------------
// fbs_front
// Accepts requests, tracks stack occupancy and wait mode, and turns each
// request into at most one command for the back.
// ----------------------------------------------------------------------------
module fbs_front #(
  parameter int STACK_DEPTH = fbs_pkg::DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  fbs_in_if.sink        in_ch,
  input  logic          q_full,
  output logic          cmd_push,
  output fbs_pkg::cmd_t cmd
);
  import fbs_pkg::*;

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] rc_r, rc_nxt;
  mode_t            mode_r, mode_nxt;
  logic             accept;
  logic             not_full;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign not_full    = (cnt_r < CNT_W'(STACK_DEPTH));

  // Classify the accepted request and update the control state
  always_comb begin
    cnt_nxt       = cnt_r;
    rc_nxt        = rc_r;
    mode_nxt      = mode_r;
    cmd_push      = 1'b0;
    cmd.op        = OP_EMIT;
    cmd.kind      = K_BUSY;
    cmd.addr      = ADDR_W'(cnt_r);
    cmd.data      = '0;
    cmd.use_pend  = 1'b0;
    cmd.emit      = 1'b1;
    cmd.refill    = 1'b0;
    if (accept) begin
      case (mode_r)
        MODE_REFILL: begin
          if (in_ch.req_type != REQ_REFILL) begin
            cmd_push = 1'b1;
          end else if (!in_ch.io_ok) begin
            cmd_push     = 1'b1;
            cmd.kind     = K_IOERR;
            cmd.use_pend = 1'b1;
            cnt_nxt      = '0;
            rc_nxt       = '0;
            mode_nxt     = MODE_IDLE;
          end else begin
            if (not_full) begin
              cmd_push = 1'b1;
              cmd.op   = OP_PUSH;
              cmd.data = in_ch.refill_word;
              cmd.emit = 1'b0;
              cnt_nxt  = CNT_W'(cnt_r + 1'b1);
            end
            if (rc_r >= CNT_W'(STACK_DEPTH - 1)) begin
              rc_nxt   = '0;
              mode_nxt = MODE_IDLE;
            end else begin
              rc_nxt = CNT_W'(rc_r + 1'b1);
            end
          end
        end
        MODE_WRITE: begin
          if (in_ch.req_type != REQ_WDONE) begin
            cmd_push = 1'b1;
          end else begin
            cmd_push     = 1'b1;
            cmd.use_pend = 1'b1;
            mode_nxt     = MODE_IDLE;
            if (!in_ch.io_ok) begin
              cmd.kind = K_IOERR;
              cnt_nxt  = '0;
            end else begin
              cmd.kind = K_RECLAIMED;
              if (not_full) begin
                cmd.op  = OP_PUSH;
                cnt_nxt = CNT_W'(cnt_r + 1'b1);
              end
            end
          end
        end
        default: begin
          mode_nxt = MODE_IDLE;
          if (in_ch.req_type == REQ_ALLOC) begin
            cmd_push = 1'b1;
            if (cnt_r == '0) begin
              cmd.kind = K_EMPTY;
            end else begin
              cmd.op     = OP_POP;
              cmd.kind   = K_GRANT;
              cmd.addr   = ADDR_W'(CNT_W'(cnt_r - 1'b1));
              cmd.refill = (cnt_r == CNT_W'(1));
              cnt_nxt    = CNT_W'(cnt_r - 1'b1);
              if (cnt_r == CNT_W'(1)) begin
                rc_nxt   = '0;
                mode_nxt = MODE_REFILL;
              end
            end
          end else if (in_ch.req_type == REQ_RECLAIM) begin
            cmd_push = 1'b1;
            cmd.data = in_ch.block_number;
            if (not_full) begin
              cmd.op   = OP_PUSH;
              cmd.kind = K_RECLAIMED;
              cnt_nxt  = CNT_W'(cnt_r + 1'b1);
            end else begin
              cmd.op   = OP_SPILL;
              cmd.kind = K_SPILL;
              cnt_nxt  = '0;
              mode_nxt = MODE_WRITE;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      rc_r   <= '0;
      mode_r <= MODE_IDLE;
    end else begin
      cnt_r  <= cnt_nxt;
      rc_r   <= rc_nxt;
      mode_r <= mode_nxt;
    end
  end

endmodule

@@ rtl/fbs_back.sv @@
// ----------------------------------------------------------------------------
// fbs_back
// Carries out queued commands against the stack memory and drives the
// registered result channel.
// ----------------------------------------------------------------------------
module fbs_back #(
  parameter int STACK_DEPTH = fbs_pkg::DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  fbs_pkg::cmd_t q_cmd,
  output logic          q_ready,
  fbs_out_if.source     out_ch
);
  import fbs_pkg::*;

  localparam int IDX_W = $clog2(STACK_DEPTH);

  logic [BLOCK_W-1:0] mem [STACK_DEPTH];

  bk_state_t          state_r, state_nxt;
  cmd_t               cmd_r;
  logic [IDX_W-1:0]   idx_r;
  logic [BLOCK_W-1:0] pend_r;
  logic [BLOCK_W-1:0] rd_data_r;

  logic               out_valid_r;
  kind_t              out_kind_r;
  logic [BLOCK_W-1:0] out_block_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic               out_last_r;

  logic               out_free;
  logic               load_cmd;
  logic               rd_en, wr_en;
  logic [IDX_W-1:0]   rd_addr, wr_addr;
  logic [BLOCK_W-1:0] wr_data;
  logic               emit;
  kind_t              emit_kind;
  logic [BLOCK_W-1:0] emit_block;
  logic [SLOT_W-1:0]  emit_slot;
  logic               emit_last;
  logic               pend_ld;
  logic [BLOCK_W-1:0] pend_val;
  logic               idx_ld;
  logic [IDX_W-1:0]   idx_val;
  logic [BLOCK_W-1:0] cmd_block;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign cmd_block = cmd_r.use_pend ? pend_r : cmd_r.data;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) state_nxt = BK_EXEC;
      end
      BK_EXEC: begin
        case (cmd_r.op)
          OP_EMIT:  if (out_free) state_nxt = BK_IDLE;
          OP_PUSH:  if (!cmd_r.emit || out_free) state_nxt = BK_IDLE;
          OP_POP:   state_nxt = BK_RDATA;
          OP_SPILL: state_nxt = BK_SPILL;
          default:  state_nxt = BK_IDLE;
        endcase
      end
      BK_RDATA: begin
        if (out_free) state_nxt = cmd_r.refill ? BK_READREQ : BK_IDLE;
      end
      BK_READREQ: begin
        if (out_free) state_nxt = BK_IDLE;
      end
      BK_SPILL: begin
        if (out_free && idx_r == '0) state_nxt = BK_WRREQ;
      end
      BK_WRREQ: begin
        if (out_free) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Memory, result and register controls
  always_comb begin
    q_ready    = (state_r == BK_IDLE);
    load_cmd   = q_valid && (state_r == BK_IDLE);
    rd_en      = 1'b0;
    rd_addr    = cmd_r.addr[IDX_W-1:0];
    wr_en      = 1'b0;
    wr_addr    = cmd_r.addr[IDX_W-1:0];
    wr_data    = cmd_block;
    emit       = 1'b0;
    emit_kind  = cmd_r.kind;
    emit_block = cmd_block;
    emit_slot  = '0;
    emit_last  = 1'b1;
    pend_ld    = 1'b0;
    pend_val   = rd_data_r;
    idx_ld     = 1'b0;
    idx_val    = IDX_W'(STACK_DEPTH - 1);
    case (state_r)
      BK_EXEC: begin
        case (cmd_r.op)
          OP_EMIT: emit = out_free;
          OP_PUSH: begin
            wr_en = !cmd_r.emit || out_free;
            emit  = cmd_r.emit && out_free;
          end
          OP_POP: rd_en = 1'b1;
          OP_SPILL: begin
            rd_en   = 1'b1;
            rd_addr = IDX_W'(STACK_DEPTH - 1);
            idx_ld  = 1'b1;
          end
          default: ;
        endcase
      end
      BK_RDATA: begin
        emit       = out_free;
        emit_kind  = K_GRANT;
        emit_block = rd_data_r;
        emit_last  = !cmd_r.refill;
        pend_ld    = out_free && cmd_r.refill;
      end
      BK_READREQ: begin
        emit       = out_free;
        emit_kind  = K_READ;
        emit_block = pend_r;
      end
      BK_SPILL: begin
        emit       = out_free;
        emit_kind  = K_SPILL;
        emit_block = rd_data_r;
        emit_slot  = SLOT_W'(idx_r);
        emit_last  = 1'b0;
        if (out_free && idx_r != '0) begin
          rd_en   = 1'b1;
          rd_addr = IDX_W'(idx_r - 1'b1);
          idx_ld  = 1'b1;
          idx_val = IDX_W'(idx_r - 1'b1);
        end
      end
      BK_WRREQ: begin
        emit       = out_free;
        emit_kind  = K_WRITE;
        emit_block = cmd_r.data;
        pend_ld    = out_free;
        pend_val   = cmd_r.data;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (pend_ld) pend_r <= pend_val;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (load_cmd) cmd_r <= q_cmd;
    if (idx_ld) idx_r <= idx_val;
    if (emit) begin
      out_kind_r  <= emit_kind;
      out_block_r <= emit_block;
      out_slot_r  <= emit_slot;
      out_last_r  <= emit_last;
    end
  end

  // Stack memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_kind  = out_kind_r;
  assign out_ch.result_block = out_block_r;
  assign out_ch.slot_index   = out_slot_r;
  assign out_ch.last_result  = out_last_r;

endmodule

@@ rtl/free_block_stack_with_spill_core.sv @@
// ----------------------------------------------------------------------------
// free_block_stack_with_spill_core
// Free block allocator: LIFO stack of free block numbers that refills from
// and spills to disk blocks of STACK_DEPTH words.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake        | payload
//  in_ch    | in  | valid/ready      | req_type, block_number, refill_word, io_ok
//  out_ch   | out | valid/ready      | result_kind, result_block, slot_index,
//           |     |                  | last_result
//
//  A request is classified in its accept cycle; the command then waits in a
//  two-entry queue. The back loads it into its command register and sends
//  each result through its output register; an allocate that empties the
//  stack gives two results. A spill reads the stack memory one word a cycle
//  while the result channel accepts. Reset is synchronous; the stack memory
//  is not cleared. A stalled result channel holds the back; the front keeps
//  accepting until the queue fills.
// ----------------------------------------------------------------------------
module free_block_stack_with_spill_core #(
  parameter int STACK_DEPTH = fbs_pkg::DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  fbs_in_if.sink    in_ch,
  fbs_out_if.source out_ch
);
  import fbs_pkg::*;
  `include "free_block_stack_with_spill_core_defines.svh"

  logic cmd_push;
  cmd_t cmd;
  logic q_full;
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  fbs_front #(.STACK_DEPTH(STACK_DEPTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .cmd_push (cmd_push),
    .cmd      (cmd)
  );

  fbs_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd),
    .full  (q_full),
    .valid (q_valid),
    .pop   (q_pop),
    .dout  (q_cmd)
  );

  fbs_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_ready (q_pop),
    .out_ch  (out_ch)
  );

  // Front never pushes into a full queue, and a pushed command is visible next
  `FBS_ASSERT_IMP(a_no_push_full, cmd_push, !q_full, "command pushed into full queue")
  `FBS_ASSERT_NXT(a_push_visible, cmd_push, q_valid, "pushed command not visible")
  // Only spill words carry a slot index, and they never close an item
  `FBS_ASSERT_IMP(a_slot_spill, out_ch.valid && out_ch.result_kind != K_SPILL, out_ch.slot_index == '0, "slot index on non-spill result")
  `FBS_ASSERT_IMP(a_spill_not_last, out_ch.valid && out_ch.result_kind == K_SPILL, !out_ch.last_result, "spill word marked last")

endmodule

@@ sim/free_block_stack_with_spill_core_tb.sv @@
// ----------------------------------------------------------------------------
// free_block_stack_with_spill_core_tb
// Self-checking bench for the free block stack. A scoreboard tracks its own
// copy of the stack and predicts grants, refills, spills, write requests,
// I/O errors and busy results for every accepted request. Results are
// compared in order as they leave the block. Both channels idle at random,
// and the result side holds off once for a long stretch so the input stalls.
// ----------------------------------------------------------------------------
module free_block_stack_with_spill_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fbs_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int ITEMS       = 100;
  localparam int ITEM_CAP    = 600;
  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_CYCLES = 150;
  localparam int MAX_SHOWN   = 10;

  typedef struct packed {
    req_t               req;
    logic [BLOCK_W-1:0] blk;
    logic [BLOCK_W-1:0] word;
    logic               ok;
  } request_t;

  typedef struct packed {
    kind_t              kind;
    logic [BLOCK_W-1:0] blk;
    logic [SLOT_W-1:0]  slot;
    logic               last;
  } result_t;

  // Free list predictor and queue of results still owed by the block
  class stack_scoreboard;
    logic [BLOCK_W-1:0] entries [DEPTH];
    int unsigned        depth_used;
    mode_t              mode;
    int unsigned        words_taken;
    logic [BLOCK_W-1:0] pend;
    result_t            due [$];
    int unsigned        mismatches;
    int unsigned        n_checked;
    int unsigned        kind_seen [8];

    function new();
      foreach (entries[i]) entries[i] = '0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
      depth_used  = 0;
      mode        = MODE_IDLE;
      words_taken = 0;
      pend        = '0;
      mismatches  = 0;
      n_checked   = 0;
    endfunction

    function void owe(kind_t k, logic [BLOCK_W-1:0] b, logic [SLOT_W-1:0] s, logic l);
      result_t r;
      r.kind = k;
      r.blk  = b;
      r.slot = s;
      r.last = l;
      due.push_back(r);
    endfunction

    function void log_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_SHOWN) $display("MISMATCH %s", msg);
    endfunction

    // Advance the stack for one accepted request and queue its results
    function void note_request(request_t rq);
      case (mode)
        MODE_REFILL: begin
          if (rq.req != REQ_REFILL) begin
            owe(K_BUSY, '0, '0, 1'b1);
          end else if (!rq.ok) begin
            depth_used  = 0;
            words_taken = 0;
            mode        = MODE_IDLE;
            owe(K_IOERR, pend, '0, 1'b1);
          end else begin
            if (depth_used < DEPTH) begin
              entries[depth_used] = rq.word;
              depth_used++;
            end
            words_taken++;
            if (words_taken >= DEPTH) begin
              words_taken = 0;
              mode        = MODE_IDLE;
            end
          end
        end
        MODE_WRITE: begin
          if (rq.req != REQ_WDONE) begin
            owe(K_BUSY, '0, '0, 1'b1);
          end else begin
            mode = MODE_IDLE;
            if (!rq.ok) begin
              depth_used = 0;
              owe(K_IOERR, pend, '0, 1'b1);
            end else begin
              if (depth_used < DEPTH) begin
                entries[depth_used] = pend;
                depth_used++;
              end
              owe(K_RECLAIMED, pend, '0, 1'b1);
            end
          end
        end
        default: begin
          mode = MODE_IDLE;
          case (rq.req)
            REQ_ALLOC: begin
              if (depth_used == 0) begin
                owe(K_EMPTY, '0, '0, 1'b1);
              end else begin
                depth_used--;
                if (depth_used != 0) begin
                  owe(K_GRANT, entries[depth_used], '0, 1'b1);
                end else begin
                  // last entry handed out: read that block to refill
                  owe(K_GRANT, entries[0], '0, 1'b0);
                  owe(K_READ, entries[0], '0, 1'b1);
                  pend        = entries[0];
                  words_taken = 0;
                  mode        = MODE_REFILL;
                end
              end
            end
            REQ_RECLAIM: begin
              if (depth_used < DEPTH) begin
                entries[depth_used] = rq.blk;
                depth_used++;
                owe(K_RECLAIMED, rq.blk, '0, 1'b1);
              end else begin
                // full: dump every entry, top first, then write the block
                for (int k = 0; k < DEPTH; k++)
                  owe(K_SPILL, entries[DEPTH-1-k], SLOT_W'(DEPTH-1-k), 1'b0);
                owe(K_WRITE, rq.blk, '0, 1'b1);
                depth_used = 0;
                pend       = rq.blk;
                mode       = MODE_WRITE;
              end
            end
            default: ;  // refill word or write completion while idle: dropped
          endcase
        end
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (!$isunknown(got.kind)) kind_seen[got.kind]++;
      n_checked++;
      if (due.size() == 0) begin
        log_mismatch($sformatf("unexpected result: kind %0d block %h slot %0d last %0d",
                               got.kind, got.blk, got.slot, got.last));
        return;
      end
      want = due.pop_front();
      if (got.kind !== want.kind || got.blk !== want.blk ||
          got.slot !== want.slot || got.last !== want.last)
        log_mismatch($sformatf(
          "expected kind %0d block %h slot %0d last %0d, got kind %0d block %h slot %0d last %0d",
          want.kind, want.blk, want.slot, want.last,
          got.kind, got.blk, got.slot, got.last));
    endfunction

    function void drain_check();
      while (due.size() != 0) begin
        result_t want;
        want = due.pop_front();
        log_mismatch($sformatf("missing result: kind %0d block %h slot %0d last %0d",
                               want.kind, want.blk, want.slot, want.last));
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  fbs_in_if  in_ch ();
  fbs_out_if out_ch ();

  stack_scoreboard sb = new();

  int unsigned n_sent   = 0;
  int unsigned n_random = 0;
  int unsigned n_out    = 0;
  int unsigned n_wok    = 0;
  int unsigned n_wfail  = 0;

  free_block_stack_with_spill_core #(
    .STACK_DEPTH (DEPTH)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [BLOCK_W-1:0] rand_block();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Offer one request, hold it until the transfer, then note it
  task automatic send_op(input req_t r, input logic [BLOCK_W-1:0] blk,
                         input logic [BLOCK_W-1:0] word, input logic ok);
    request_t rq;
    rq.req  = r;
    rq.blk  = blk;
    rq.word = word;
    rq.ok   = ok;
    @(negedge clk);
    while (!(n_sent >= 50 && n_sent < 80) && $urandom_range(99) < 33) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid        = 1'b1;
    in_ch.req_type     = r;
    in_ch.block_number = blk;
    in_ch.refill_word  = word;
    in_ch.io_ok        = ok;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_request(rq);
    n_sent++;
  endtask

  // Mostly well-formed allocate/refill/spill cycles with some noise mixed in
  task automatic random_traffic();
    req_t r;
    logic ok;
    int   pick;
    bit   counted;
    bit   is_wdone;
    while ((n_random < ITEMS || n_wok == 0 || n_wfail == 0) && n_random < ITEM_CAP) begin
      r        = req_t'(REQ_W'($urandom_range(3)));
      ok       = 1'($urandom_range(1));
      counted  = 1'b1;
      is_wdone = 1'b0;
      pick     = $urandom_range(99);
      case (sb.mode)
        MODE_REFILL: begin
          if (pick >= 8) begin
            r  = REQ_REFILL;
            ok = ($urandom_range(99) != 0);
          end else begin
            case ($urandom_range(2))
              0:       r = REQ_ALLOC;
              1:       r = REQ_RECLAIM;
              default: r = REQ_WDONE;
            endcase
          end
        end
        MODE_WRITE: begin
          if (pick >= 20) begin
            r        = REQ_WDONE;
            is_wdone = 1'b1;
            if (n_wok == 0)        ok = 1'b1;
            else if (n_wfail == 0) ok = 1'b0;
            else                   ok = ($urandom_range(99) < 70);
          end else begin
            case ($urandom_range(2))
              0:       r = REQ_ALLOC;
              1:       r = REQ_RECLAIM;
              default: r = REQ_REFILL;
            endcase
          end
        end
        default: begin
          if (pick < 6) begin
            r       = $urandom_range(1) ? REQ_REFILL : REQ_WDONE;
            counted = 1'b0;
          end else if (sb.depth_used == DEPTH) begin
            r = (pick < 90) ? REQ_RECLAIM : REQ_ALLOC;
          end else if (sb.depth_used > DEPTH / 2) begin
            r = (pick < 75) ? REQ_RECLAIM : REQ_ALLOC;
          end else begin
            r = (pick < 62) ? REQ_ALLOC : REQ_RECLAIM;
          end
        end
      endcase
      send_op(r, rand_block(), rand_block(), ok);
      if (counted) n_random++;
      if (is_wdone) begin
        if (ok) n_wok++;
        else    n_wfail++;
      end
    end
  endtask

  // Reset, directed cases, random traffic, drain and verdict
  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.req_type     = REQ_ALLOC;
    in_ch.block_number = '0;
    in_ch.refill_word  = '0;
    in_ch.io_ok        = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty stack, dropped requests while idle
    send_op(REQ_ALLOC,   $urandom, $urandom, 1'b1);
    send_op(REQ_REFILL,  $urandom, '1, 1'b1);
    send_op(REQ_WDONE,   $urandom, $urandom, 1'b0);
    // push extremes, pop down to empty to start a refill
    send_op(REQ_RECLAIM, '0, $urandom, 1'b0);
    send_op(REQ_RECLAIM, '1, $urandom, 1'b1);
    send_op(REQ_ALLOC,   $urandom, $urandom, 1'b1);
    send_op(REQ_ALLOC,   $urandom, $urandom, 1'b0);
    // anything but a refill word is busy while refilling
    send_op(REQ_ALLOC,   $urandom, $urandom, 1'b1);
    send_op(REQ_RECLAIM, '1, $urandom, 1'b1);
    send_op(REQ_WDONE,   $urandom, $urandom, 1'b1);
    // partial refill, then a read failure drops it
    send_op(REQ_REFILL,  $urandom, '1, 1'b1);
    send_op(REQ_REFILL,  $urandom, '0, 1'b1);
    send_op(REQ_REFILL,  $urandom, $urandom, 1'b0);
    send_op(REQ_ALLOC,   $urandom, $urandom, 1'b1);
    // start another refill for the random part to complete
    send_op(REQ_RECLAIM, 32'h8000_0001, $urandom, 1'b1);
    send_op(REQ_RECLAIM, 32'h7FFF_FFFE, $urandom, 1'b0);
    send_op(REQ_ALLOC,   $urandom, $urandom, 1'b0);
    send_op(REQ_ALLOC,   $urandom, $urandom, 1'b1);

    random_traffic();
    @(negedge clk);
    in_ch.valid = 1'b0;

    // drain, then watch for stray results
    while (sb.due.size() != 0) @(posedge clk);
    repeat (DEPTH + 10) @(posedge clk);
    sb.drain_check();

    $display("Sent %0d requests (%0d random), checked %0d results, %0d mismatches.",
             n_sent, n_random, sb.n_checked, sb.mismatches);
    $display("Grants %0d, empty %0d, reads %0d, spill words %0d, writes %0d, %s",
             sb.kind_seen[K_GRANT], sb.kind_seen[K_EMPTY], sb.kind_seen[K_READ],
             sb.kind_seen[K_SPILL], sb.kind_seen[K_WRITE],
             $sformatf("reclaimed %0d, io errors %0d, busy %0d.",
                       sb.kind_seen[K_RECLAIMED], sb.kind_seen[K_IOERR],
                       sb.kind_seen[K_BUSY]));
    if (sb.mismatches == 0) begin
      $display("free_block_stack_with_spill_core test passed");
    end else begin
      $display("free_block_stack_with_spill_core test failed");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off, one stretch always ready
  initial begin : result_sink
    bit held;
    int hold_left;
    held          = 1'b0;
    hold_left     = 0;
    out_ch.ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else if (!held && n_out >= 30) begin
        held         = 1'b1;
        hold_left    = HOLD_CYCLES - 1;
        out_ch.ready = 1'b0;
      end else if (n_out >= 100 && n_out < 160) begin
        out_ch.ready = 1'b1;
      end else begin
        out_ch.ready = ($urandom_range(99) >= 33);
      end
    end
  end

  // Check each result transfer against the oldest owed result
  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.kind = kind_t'(out_ch.result_kind);
      got.blk  = out_ch.result_block;
      got.slot = out_ch.slot_index;
      got.last = out_ch.last_result;
      sb.check_result(got);
      n_out++;
    end
  end

  // Stop the run if no transfer happens on either channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
    $display("free_block_stack_with_spill_core test failed");
    $finish;
  end

endmodule
